@@ rtl/cme_pkg.sv @@
// shared types and constants for the celtic mandelbrot escape-time core
// no dependencies

package cme_pkg;

	localparam int unsigned FracBits = 28;
	localparam int unsigned QW       = 32;
	localparam int unsigned PixW     = 12;
	localparam int unsigned StepW    = 29;
	localparam int unsigned IterW    = 16;
	localparam int unsigned CfgIdxW  = 2;

	localparam int unsigned DefImageWidth  = 1024;
	localparam int unsigned DefImageHeight = 1024;

	localparam logic signed [QW-1:0] ResetOriginRe = 32'shD3333333;
	localparam logic signed [QW-1:0] ResetOriginIm = 32'shDB333333;
	localparam logic [StepW-1:0]     ResetStep     = 29'd1342177;
	localparam logic [IterW-1:0]     ResetMaxIter  = 16'd50;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ORIGIN_RE = 2'd0,
		REG_ORIGIN_IM = 2'd1,
		REG_STEP      = 2'd2,
		REG_MAX_ITER  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_SAT,
		ST_ITER,
		ST_DONE
	} state_t;

	// one cell of the iteration chain: the point and the live iterate
	typedef struct packed {
		logic signed [QW-1:0] c;
		logic signed [QW-1:0] z;
	} lane_t;

	// control from the sequencer to the iteration cells
	typedef struct packed {
		logic load;
		logic step;
	} cell_ctrl_t;

	function automatic logic signed [QW-1:0] sat_q(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (x > hi) return 32'sh7FFFFFFF;
		else if (x < lo) return 32'sh80000000;
		else return x[QW-1:0];
	endfunction

endpackage

@@ rtl/celtic_mandelbrot_escape_time_core.sv @@
// celtic mandelbrot escape-time core: maps a pixel to c and iterates
// |re^2-im^2|+c_re, 2*re*im+c_im; depends on cme_pkg, cme_cell, cme_products
//
// one pixel at a time: an item passes through acceptance, mapping, loading the
// cells, up to max_iter iteration steps (fewer on escape) and the final test
// that writes the result register. The iteration loop runs through the two
// cells (real and imaginary) and the shared multiplier stage, one map step per
// cycle. The result sits in an output register; a new pixel is taken once the
// previous result has moved into that register, and a result that is not
// collected holds the next pixel at the end of its iteration.

module celtic_mandelbrot_escape_time_core #(
	parameter int unsigned IMAGE_WIDTH  = cme_pkg::DefImageWidth,
	parameter int unsigned IMAGE_HEIGHT = cme_pkg::DefImageHeight
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cme_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cme_pkg::PixW-1:0]      pixel_x,
	input  logic [cme_pkg::PixW-1:0]      pixel_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cme_pkg::PixW-1:0]      out_x,
	output logic [cme_pkg::PixW-1:0]      out_y,
	output logic [cme_pkg::IterW-1:0]     iterations
);
	import cme_pkg::*;

	// pixels beyond the image are handled like any other
	localparam int unsigned ImgCheck = IMAGE_WIDTH + IMAGE_HEIGHT;

	logic signed [QW-1:0] origin_re_q, origin_im_q;
	logic [StepW-1:0]     step_q;
	logic [IterW-1:0]     max_iter_q;

	state_t state_q, state_d;
	logic [PixW-1:0]   px_q, py_q;
	logic [IterW-1:0]  count_q;
	logic [41:0] mre_s1, mim_s1;
	logic signed [QW-1:0] c_re, c_im;
	logic out_valid_q;
	logic [PixW-1:0] ox_q, oy_q;
	logic [IterW-1:0] it_q;

	cell_ctrl_t ctrl;
	lane_t re_lane, im_lane;
	logic signed [65:0] re_term, im_term;
	logic escaped, iter_go;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && (ImgCheck != 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= ResetOriginRe;
			origin_im_q <= ResetOriginIm;
			step_q      <= ResetStep;
			max_iter_q  <= ResetMaxIter;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_RE: origin_re_q <= cfg_data;
				REG_ORIGIN_IM: origin_im_q <= cfg_data;
				REG_STEP:      step_q <= cfg_data[StepW-1:0];
				REG_MAX_ITER:  max_iter_q <= cfg_data[IterW-1:0];
				default: ;
			endcase
		end
	end

	assign iter_go = (count_q < max_iter_q) && !escaped;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MAP;
			ST_MAP:  state_d = ST_SAT;
			ST_SAT:  state_d = ST_ITER;
			ST_ITER: if (!iter_go && (!out_valid_q || out_ready)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.load = (state_q == ST_SAT);
		ctrl.step = (state_q == ST_ITER) && iter_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ITER && !iter_go && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (state_q == ST_MAP) begin
			mre_s1 <= 42'(px_q) * 42'(step_q);
			mim_s1 <= 42'(py_q) * 42'(step_q);
		end
		if (ctrl.load) count_q <= '0;
		else if (ctrl.step) count_q <= count_q + 1'b1;
		if (state_q == ST_ITER && !iter_go && (!out_valid_q || out_ready)) begin
			ox_q <= px_q;
			oy_q <= py_q;
			it_q <= count_q;
		end
	end

	assign c_re = sat_q(66'(origin_re_q) + 66'(signed'({1'b0, mre_s1})));
	assign c_im = sat_q(66'(origin_im_q) + 66'(signed'({1'b0, mim_s1})));

	cme_cell u_re (
		.clk(clk), .ctrl(ctrl), .c_in(c_re), .term(re_term),
		.shift(6'd28), .lane(re_lane)
	);
	cme_cell u_im (
		.clk(clk), .ctrl(ctrl), .c_in(c_im), .term(im_term),
		.shift(6'd27), .lane(im_lane)
	);
	cme_products u_prod (
		.clk(clk), .re_lane(re_lane), .im_lane(im_lane),
		.re_term(re_term), .im_term(im_term), .escaped(escaped)
	);

	assign out_valid  = out_valid_q;
	assign out_x      = ox_q;
	assign out_y      = oy_q;
	assign iterations = it_q;
endmodule

@@ rtl/cme_cell.sv @@
// one iteration cell: holds one coordinate of z and c, takes its own product
// term from the product stage; depends on cme_pkg

module cme_cell (
	input  logic                      clk,
	input  cme_pkg::cell_ctrl_t       ctrl,
	input  logic signed [31:0]        c_in,
	input  logic signed [65:0]        term,
	input  logic [5:0]                shift,
	output cme_pkg::lane_t            lane
);
	import cme_pkg::*;

	lane_t lane_q;
	logic signed [65:0] red;

	// arithmetic shift is floor division
	assign red = term >>> shift;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			lane_q.c <= c_in;
			lane_q.z <= '0;
		end else if (ctrl.step) begin
			lane_q.z <= sat_q(red + 66'(lane_q.c));
		end
	end

	assign lane = lane_q;
endmodule

@@ rtl/cme_products.sv @@
// product stage between the two cells: squares, cross product, escape test
// depends on cme_pkg

module cme_products (
	input  logic                  clk,
	input  cme_pkg::lane_t        re_lane,
	input  cme_pkg::lane_t        im_lane,
	output logic signed [65:0]    re_term,
	output logic signed [65:0]    im_term,
	output logic                  escaped
);
	import cme_pkg::*;

	logic signed [63:0] rr, ii, ri;
	logic signed [64:0] d;
	logic [64:0] mag;

	assign rr = 64'(re_lane.z) * 64'(re_lane.z);
	assign ii = 64'(im_lane.z) * 64'(im_lane.z);
	assign ri = 64'(re_lane.z) * 64'(im_lane.z);
	assign d  = 65'(rr) - 65'(ii);

	assign re_term = d[64] ? -66'(d) : 66'(d);
	assign im_term = 66'(ri);

	assign mag = {1'b0, rr} + {1'b0, ii};
	assign escaped = mag >= (65'd4 << 56);

	// the stage is combinational, the clock is not used
	logic unused_clk;
	assign unused_clk = clk;
endmodule

@@ sim/cme_escape_checker.sv @@
// checker for the celtic mandelbrot escape-time core: tracks the register
// writes, computes the escape count of every accepted pixel and compares results
// depends on cme_pkg
`timescale 1ns / 100ps

module cme_escape_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [cme_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [cme_pkg::PixW-1:0]    pixel_x,
	input  logic [cme_pkg::PixW-1:0]    pixel_y,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [cme_pkg::PixW-1:0]    out_x,
	input  logic [cme_pkg::PixW-1:0]    out_y,
	input  logic [cme_pkg::IterW-1:0]   iterations,
	output int                          failures,
	output int                          pending
);
	import cme_pkg::*;

	typedef struct {
		logic [PixW-1:0]  x;
		logic [PixW-1:0]  y;
		logic [IterW-1:0] iters;
	} pixel_result_t;

	logic signed [QW-1:0] view_re;
	logic signed [QW-1:0] view_im;
	logic [StepW-1:0]     view_step;
	logic [IterW-1:0]     iter_limit;
	pixel_result_t        pixel_results_q[$];
	int                   mismatches;

	function automatic longint clamp_q(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [IterW-1:0] escape_count(input logic [PixW-1:0] px,
			input logic [PixW-1:0] py);
		longint c_re, c_im, re, im, rr, ii, ri, d;
		longint unsigned mag;
		int unsigned count;
		c_re = clamp_q(longint'(view_re) + longint'(px) * longint'(view_step));
		c_im = clamp_q(longint'(view_im) + longint'(py) * longint'(view_step));
		re = 0;
		im = 0;
		count = 0;
		forever begin
			mag = longint'(re * re) + longint'(im * im);
			if (count >= iter_limit || mag >= (64'd4 << 56)) break;
			rr = re * re;
			ii = im * im;
			ri = re * im;
			d = rr - ii;
			if (d < 0) d = -d;
			// arithmetic shift of a signed value floors toward minus infinity
			re = clamp_q((d >>> FracBits) + c_re);
			im = clamp_q((ri >>> (FracBits - 1)) + c_im);
			count++;
		end
		return count[IterW-1:0];
	endfunction

	assign pending = pixel_results_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		pixel_result_t exp_r;
		if (!arst_n) begin
			view_re    <= ResetOriginRe;
			view_im    <= ResetOriginIm;
			view_step  <= ResetStep;
			iter_limit <= ResetMaxIter;
			failures   <= 0;
			mismatches <= 0;
			pixel_results_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_ORIGIN_RE: view_re <= cfg_data;
					REG_ORIGIN_IM: view_im <= cfg_data;
					REG_STEP:      view_step <= cfg_data[StepW-1:0];
					REG_MAX_ITER:  iter_limit <= cfg_data[IterW-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				exp_r.x = pixel_x;
				exp_r.y = pixel_y;
				exp_r.iters = escape_count(pixel_x, pixel_y);
				pixel_results_q.push_back(exp_r);
			end
			if (out_valid && out_ready) begin
				if (pixel_results_q.size() == 0) begin
					failures <= failures + 1;
					if (mismatches < 10)
						$display("unexpected result x=%0d y=%0d iterations=%0d",
							out_x, out_y, iterations);
					mismatches <= mismatches + 1;
				end else begin
					exp_r = pixel_results_q.pop_front();
					if (exp_r.x !== out_x || exp_r.y !== out_y || exp_r.iters !== iterations) begin
						failures <= failures + 1;
						if (mismatches < 10)
							$display("mismatch: expected x=%0d y=%0d it=%0d, got x=%0d y=%0d it=%0d",
								exp_r.x, exp_r.y, exp_r.iters, out_x, out_y, iterations);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

@@ sim/tb_celtic_mandelbrot_escape_time_core.sv @@
// testbench top for the celtic mandelbrot escape-time core: clock, reset,
// register phases, pixel and result traffic, verdict; uses cme_escape_checker
`timescale 1ns / 100ps

module tb_celtic_mandelbrot_escape_time_core;
	import cme_pkg::*;

	localparam int IdleLimit = 300000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [PixW-1:0]    pixel_x = '0;
	logic [PixW-1:0]    pixel_y = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PixW-1:0]    out_x;
	logic [PixW-1:0]    out_y;
	logic [IterW-1:0]   iterations;
	int                 failures;
	int                 pending;
	int                 idle_cycles = 0;
	int                 results_seen = 0;
	int                 burst_left = 0;

	always #6 clk = ~clk;

	celtic_mandelbrot_escape_time_core dut (.*);

	cme_escape_checker chk (.*);

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (out_valid && out_ready) results_seen <= results_seen + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: changing stall pattern, plus one long hold-off to back up the input
	initial begin
		int mode;
		bit held;
		held = 0;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				if (!held && results_seen >= 100) begin
					held = 1;
					out_ready <= 1'b0;
					repeat (600) @(posedge clk);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// bursts of back-to-back transactions separated by random gaps
	task automatic send_pixel(input logic [PixW-1:0] x, input logic [PixW-1:0] y);
		in_valid <= 1'b1;
		pixel_x  <= x;
		pixel_y  <= y;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	endtask

	task automatic drain;
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_view(input logic [31:0] re, input logic [31:0] im,
			input logic [31:0] step, input logic [31:0] lim);
		drain();
		write_reg(REG_ORIGIN_RE, re);
		write_reg(REG_ORIGIN_IM, im);
		write_reg(REG_STEP, step);
		write_reg(REG_MAX_ITER, lim);
	endtask

	task automatic random_pixel;
		// mostly the visible image, sometimes anywhere in the field range
		if ($urandom_range(0, 4) != 0)
			send_pixel(PixW'($urandom_range(0, 1023)), PixW'($urandom_range(0, 1023)));
		else
			send_pixel(PixW'($urandom), PixW'($urandom));
	endtask

	initial begin
		logic [31:0] r_re, r_im, r_step, r_lim;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults after reset: corners and a point near the set
		send_pixel(0, 0);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(0, 12'hFFF);
		send_pixel(12'hFFF, 0);
		send_pixel(560, 460);
		send_pixel(400, 460);
		send_pixel(1023, 1023);
		send_pixel(1024, 1024);
		// large coordinates saturate
		set_view(32'h7FFFFFFF, 32'h80000000, 32'h10000000, 32'd50);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(0, 0);
		send_pixel(12'hFFF, 0);
		// zero step, origin inside the set
		set_view(32'hF0000000, 32'h00000000, 32'h0, 32'd64);
		send_pixel(12'hABC, 12'h543);
		send_pixel(0, 12'hFFF);
		// zero and one iteration limit
		set_view(32'hD3333333, 32'hDB333333, 32'd1342177, 32'h0);
		send_pixel(560, 460);
		send_pixel(0, 0);
		set_view(32'hD3333333, 32'hDB333333, 32'd1342177, 32'hFFFF0001);
		send_pixel(560, 460);
		send_pixel(0, 0);
		// largest limit, only a handful of items
		set_view(32'hE0000000, 32'hF0000000, 32'h1000000, 32'hFFFFFFFF);
		send_pixel(16, 16);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(0, 0);

		for (int phase = 0; phase < 24; phase++) begin
			if (phase % 4 == 3) begin
				r_re = $urandom;
				r_im = $urandom;
				r_step = $urandom;
			end else begin
				r_re = 32'hD0000000 + $urandom_range(0, 32'h08000000);
				r_im = 32'hD8000000 + $urandom_range(0, 32'h08000000);
				r_step = {3'($urandom_range(0, 7)), 29'd0} | $urandom_range(1, 2000000);
			end
			r_lim = {16'($urandom), 16'd0} | $urandom_range(1, 100);
			set_view(r_re, r_im, r_step, r_lim);
			repeat (50) random_pixel();
		end
		drain();
		repeat (60) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
